// ----- rtl/csvri_pkg.sv -----
// csvri_pkg: shared types and constants for the CSV row indexer.
// Holds the request and result structs, parse phase codes and character constants.
// No dependencies.
package csvri_pkg;

  localparam int unsigned ROW_W = 32;
  localparam int unsigned ACC_W = ROW_W + 4;

  localparam logic [ROW_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [ROW_W-1:0] NEG_LIMIT = 32'h8000_0000;
  localparam logic [ROW_W-1:0] LEN_MAX   = 32'hFFFF_FFFF;
  localparam logic [ROW_W-1:0] CAP_RESET = 32'hFFFF_FFFF;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_EOF  = 1'b1;

  typedef enum logic [3:0] {
    PH_SPACE  = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic       func;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    logic signed [ROW_W-1:0] row_id;
    logic [ROW_W-1:0]        text_offset;
    logic [ROW_W-1:0]        text_length;
    logic [ROW_W-1:0]        row_number;
    logic                    ids_sequential;
    logic                    capacity_error;
  } rsp_t;

  typedef struct packed {
    logic step;
    logic clear;
  } id_ctl_t;

endpackage

// ----- rtl/csvri_id_parser.sv -----
// csvri_id_parser: atoi-style ID parser with whitespace skip, sign and saturation.
// Uses csvri_pkg; driven by csvri_row_ctl through an id_ctl_t.
module csvri_id_parser
  import csvri_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  id_ctl_t                 ctl_i,
  input  logic [7:0]              data_i,
  output logic signed [ROW_W-1:0] id_o
);

  phase_e           phase_q, phase_d;
  logic             neg_q, neg_d;
  logic [ROW_W-1:0] mag_q, mag_d;

  logic             is_digit, is_ws, is_sign;
  logic [3:0]       digit;
  logic [ROW_W-1:0] limit;
  logic [ACC_W-1:0] acc;
  logic [ROW_W-1:0] mag_acc;

  assign is_digit = (data_i >= CH_ZERO) && (data_i <= CH_NINE);
  assign is_ws    = (data_i == CH_SPACE) || (data_i == CH_TAB) || (data_i == CH_CR) ||
                    (data_i == CH_VT) || (data_i == CH_FF);
  assign is_sign  = (data_i == CH_PLUS) || (data_i == CH_MINUS);
  assign digit    = 4'(data_i - CH_ZERO);
  assign limit    = neg_q ? NEG_LIMIT : POS_LIMIT;
  assign acc      = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + ACC_W'(digit);
  assign mag_acc  = (acc > ACC_W'(limit)) ? limit : acc[ROW_W-1:0];

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    if (ctl_i.clear) begin
      phase_d = PH_SPACE;
      neg_d   = 1'b0;
      mag_d   = '0;
    end else if (ctl_i.step) begin
      case (phase_q)
        PH_SPACE: begin
          if (is_ws) begin
            phase_d = PH_SPACE;
          end else if (is_sign) begin
            neg_d   = (data_i == CH_MINUS);
            phase_d = PH_SIGN;
          end else if (is_digit) begin
            mag_d   = mag_acc;
            phase_d = PH_DIGITS;
          end else begin
            phase_d = PH_DONE;
          end
        end
        PH_SIGN, PH_DIGITS: begin
          if (is_digit) begin
            mag_d   = mag_acc;
            phase_d = PH_DIGITS;
          end else begin
            phase_d = PH_DONE;
          end
        end
        PH_DONE: begin
          phase_d = PH_DONE;
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SPACE;
      neg_q   <= 1'b0;
      mag_q   <= '0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
    end
  end

  assign id_o = neg_q ? $signed(ROW_W'(0) - mag_q) : $signed(mag_q);

endmodule

// ----- rtl/csvri_row_ctl.sv -----
// csvri_row_ctl: line and row state, capacity check and result formation.
// Uses csvri_pkg and csvri_id_parser.
module csvri_row_ctl
  import csvri_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             proc_i,
  input  req_t             req_i,
  input  logic [ROW_W-1:0] capacity_i,
  output logic             res_valid_o,
  output rsp_t             res_o,
  output logic             stopped_o
);

  logic [OFFSET_BITS-1:0] byte_ofs_q, text_ofs_q;
  logic                   seen_comma_q, last_cr_q, seq_q, stopped_q;
  logic [ROW_W-1:0]       text_len_q, rows_q, line_id_q;

  logic                    do_byte, do_eof, is_nl, is_comma, finish, row_due, cap_hit, seq_ok;
  logic [ROW_W-1:0]        rows_inc, len_out;
  logic signed [ROW_W-1:0] id_val;
  id_ctl_t                 id_ctl;

  assign is_nl    = (req_i.data == CH_NL);
  assign is_comma = (req_i.data == CH_COMMA);
  assign do_byte  = proc_i && !stopped_q && (req_i.func == FUNC_DATA);
  assign do_eof   = proc_i && !stopped_q && (req_i.func == FUNC_EOF);
  assign finish   = do_eof || (do_byte && is_nl);
  assign row_due  = finish && seen_comma_q;
  assign cap_hit  = (rows_q >= capacity_i);
  assign rows_inc = rows_q + ROW_W'(1);
  assign seq_ok   = seq_q && (line_id_q == rows_inc);
  assign len_out  = (last_cr_q && (text_len_q != '0)) ? text_len_q - ROW_W'(1) : text_len_q;

  assign id_ctl.clear = finish;
  assign id_ctl.step  = do_byte && !seen_comma_q && !is_comma && !is_nl;

  csvri_id_parser u_id_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (id_ctl),
    .data_i (req_i.data),
    .id_o   (id_val)
  );

  always_comb begin
    res_o = '0;
    if (cap_hit) begin
      res_o.capacity_error = 1'b1;
    end else begin
      res_o.row_id         = $signed(line_id_q);
      res_o.text_offset    = ROW_W'(text_ofs_q);
      res_o.text_length    = len_out;
      res_o.row_number     = rows_inc;
      res_o.ids_sequential = seq_ok;
    end
  end

  assign res_valid_o = row_due;
  assign stopped_o   = stopped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_ofs_q   <= '0;
      text_ofs_q   <= '0;
      seen_comma_q <= 1'b0;
      last_cr_q    <= 1'b0;
      text_len_q   <= '0;
      line_id_q    <= '0;
      rows_q       <= '0;
      seq_q        <= 1'b1;
      stopped_q    <= 1'b0;
    end else begin
      if (do_byte) begin
        byte_ofs_q <= byte_ofs_q + OFFSET_BITS'(1);
      end
      if (row_due && cap_hit) begin
        stopped_q <= 1'b1;
      end else if (row_due) begin
        rows_q <= rows_inc;
        seq_q  <= seq_ok;
      end
      if (finish) begin
        seen_comma_q <= 1'b0;
        text_ofs_q   <= '0;
        text_len_q   <= '0;
        last_cr_q    <= 1'b0;
        line_id_q    <= '0;
      end else if (do_byte && !seen_comma_q && is_comma) begin
        seen_comma_q <= 1'b1;
        line_id_q    <= ROW_W'(id_val);
        text_ofs_q   <= byte_ofs_q + OFFSET_BITS'(1);
      end else if (do_byte && seen_comma_q) begin
        if (text_len_q != LEN_MAX) begin
          text_len_q <= text_len_q + ROW_W'(1);
        end
        last_cr_q <= (req_i.data == CH_CR);
      end
    end
  end

endmodule

// ----- rtl/csv_row_indexer.sv -----
// csv_row_indexer: top level of the CSV row indexer.
// Uses csvri_pkg and csvri_row_ctl; holds the input, capacity and result registers.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_req_i) carries one request per byte:
//   func 0 with a file byte in data, or func 1 to flush the pending line at end
//   of file. Output channel (out_valid_o/out_ready_i, out_rsp_o) carries one
//   result per indexed row, or a single result with capacity_error set once
//   more rows arrive than row_capacity allows; after that the block drops all
//   requests and gives no more results until reset.
//   A result passes the input register and then the result register: the
//   accepting edge loads the request into the input register, and the result
//   register loads when that request is processed and the result side can move.
//   Throughput: one request per cycle unless the receiver stalls; the per-byte ID
//   update is one multiply-by-ten accumulate and compare between the two registers.
//   When the receiver stalls, the result register holds and the request waiting
//   in the input register holds; in_ready_o stays high while either can move.
//   cfg_we_i/cfg_wdata_i write row_capacity; write it only while idle.
//   Reset: row_capacity is all ones, byte offset, row count and line state clear,
//   and the sequential-ID flag is set.
module csv_row_indexer
  import csvri_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rsp_t             out_rsp_o,
  input  logic             cfg_we_i,
  input  logic [ROW_W-1:0] cfg_wdata_i
);

  logic             in_valid_q, out_valid_q;
  req_t             in_req_q;
  rsp_t             out_rsp_q, res;
  logic [ROW_W-1:0] capacity_q;
  logic             adv, proc, res_valid, stopped;

  assign adv        = !out_valid_q || out_ready_i;
  assign proc       = in_valid_q && adv;
  assign in_ready_o = !in_valid_q || adv;

  csvri_row_ctl #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_row_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .proc_i      (proc),
    .req_i       (in_req_q),
    .capacity_i  (capacity_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .stopped_o   (stopped)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      capacity_q  <= CAP_RESET;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= proc && res_valid;
      end
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_req_q <= in_req_i;
    end
    if (adv && proc && res_valid) begin
      out_rsp_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped |-> !res_valid)
    else $error("result formed after capacity stop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && res_valid && res.capacity_error) |=> stopped)
    else $error("capacity error did not stop the block");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_rsp_o.capacity_error) |-> (out_rsp_o.row_number != '0))
    else $error("row result with zero row number");

endmodule

// ----- test/csv_row_indexer_tb.sv -----
// csv_row_indexer_tb: self-checking bench for the CSV row indexer.
// Streams byte and end-of-file requests, predicts each row and the capacity error,
// and matches them on the result channel. Depends on csvri_pkg and csv_row_indexer.
module csv_row_indexer_tb;
  import csvri_pkg::*;

  localparam int LIMIT = 200000;
  localparam int LAT_PAD = 4;
  localparam logic [7:0] WS_CHARS [5] = '{CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF};

  class row_tracker;
    rsp_t rows_due[$];
    int errors;
    logic [ROW_W-1:0] capacity;
    logic [ROW_W-1:0] offset;
    logic [ROW_W-1:0] line_ofs;
    logic [ROW_W-1:0] line_len;
    logic [ROW_W-1:0] id_mag;
    logic [ROW_W-1:0] line_id;
    logic [ROW_W-1:0] rows_seen;
    logic comma_seen;
    logic cr_last;
    logic id_neg;
    logic seq_ok;
    logic halted;
    phase_e phase;

    function new();
      errors = 0;
      capacity = CAP_RESET;
      offset = '0;
      rows_seen = '0;
      seq_ok = 1'b1;
      halted = 1'b0;
      clear_line();
    endfunction

    function void clear_line();
      comma_seen = 1'b0;
      line_ofs = '0;
      line_len = '0;
      cr_last = 1'b0;
      phase = PH_SPACE;
      id_neg = 1'b0;
      id_mag = '0;
      line_id = '0;
    endfunction

    function void set_capacity(logic [ROW_W-1:0] v);
      capacity = v;
    endfunction

    function int pending();
      return rows_due.size();
    endfunction

    function void parse_id_char(logic [7:0] c);
      logic [ROW_W-1:0] digit;
      logic [ROW_W-1:0] lim;
      if (phase == PH_DONE) return;
      if (phase == PH_SPACE) begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF) return;
        if (c == CH_PLUS || c == CH_MINUS) begin
          id_neg = (c == CH_MINUS);
          phase = PH_SIGN;
          return;
        end
      end
      if (c < CH_ZERO || c > CH_NINE) begin
        phase = PH_DONE;
        return;
      end
      phase = PH_DIGITS;
      digit = c - CH_ZERO;
      lim = id_neg ? NEG_LIMIT : POS_LIMIT;
      if (id_mag > (lim - digit) / 10) begin
        id_mag = lim;
      end else begin
        id_mag = id_mag * 10 + digit;
      end
    endfunction

    function logic [ROW_W-1:0] id_value();
      if (!id_neg) return id_mag;
      if (id_mag >= NEG_LIMIT) return NEG_LIMIT;
      return -id_mag;
    endfunction

    function void close_line();
      rsp_t row;
      logic [ROW_W-1:0] len;
      if (comma_seen) begin
        row = '0;
        len = line_len;
        if (len != 0 && cr_last) len = len - 1;
        if (rows_seen >= capacity) begin
          row.capacity_error = 1'b1;
          rows_due.push_back(row);
          halted = 1'b1;
          return;
        end
        rows_seen = rows_seen + 1;
        if (line_id != rows_seen) seq_ok = 1'b0;
        row.row_id = line_id;
        row.text_offset = line_ofs;
        row.text_length = len;
        row.row_number = rows_seen;
        row.ids_sequential = seq_ok;
        rows_due.push_back(row);
      end
      clear_line();
    endfunction

    function void take_request(req_t r);
      logic [ROW_W-1:0] here;
      if (halted) return;
      if (r.func == FUNC_EOF) begin
        close_line();
        return;
      end
      here = offset;
      offset = offset + 1;
      if (r.data == CH_NL) begin
        close_line();
      end else if (!comma_seen) begin
        if (r.data == CH_COMMA) begin
          comma_seen = 1'b1;
          line_id = id_value();
          line_ofs = here + 1;
        end else begin
          parse_id_char(r.data);
        end
      end else begin
        if (line_len != LEN_MAX) line_len = line_len + 1;
        cr_last = (r.data == CH_CR);
      end
    endfunction

    function void check_field(string name, logic [ROW_W-1:0] want, logic [ROW_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void match_row(rsp_t got);
      rsp_t want;
      if (rows_due.size() == 0) begin
        errors++;
        $display("%0t: result with none due, actual %h", $time, got);
        return;
      end
      want = rows_due.pop_front();
      check_field("row_id", want.row_id, got.row_id);
      check_field("text_offset", want.text_offset, got.text_offset);
      check_field("text_length", want.text_length, got.text_length);
      check_field("row_number", want.row_number, got.row_number);
      check_field("ids_sequential", want.ids_sequential, got.ids_sequential);
      check_field("capacity_error", want.capacity_error, got.capacity_error);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_rsp;
  logic cfg_we = 1'b0;
  logic [ROW_W-1:0] cfg_wdata = '0;

  row_tracker tracker;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;
  int sent = 0;

  csv_row_indexer #(.OFFSET_BITS(32)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial forever #5 clk = ~clk;

  task automatic send_req(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (!in_ready);
    tracker.take_request(r);
    sent++;
  endtask

  task automatic send_data(input logic [7:0] b);
    send_req('{func: FUNC_DATA, data: b});
  endtask

  task automatic send_eof();
    send_req('{func: FUNC_EOF, data: 8'($urandom_range(255))});
  endtask

  task automatic send_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_data(s[i]);
  endtask

  function automatic string digit_run(int n);
    string s;
    s = "";
    repeat (n) s = $sformatf("%s%0d", s, $urandom_range(9));
    return s;
  endfunction

  task automatic send_line();
    logic [7:0] q[$];
    logic [7:0] b;
    string id;
    int n;
    int i;
    n = $urandom_range(2);
    repeat (n) q.push_back(WS_CHARS[$urandom_range(4)]);
    case ($urandom_range(9))
      0, 1, 2, 3: id = $sformatf("%0d", tracker.rows_seen + 1);
      4: id = $sformatf("%0d", $signed($urandom()));
      5: id = digit_run($urandom_range(10, 14));
      6: begin
        case ($urandom_range(2))
          0: id = "";
          1: id = "+";
          default: id = "-";
        endcase
      end
      7: id = $sformatf("%0d%s", $urandom_range(20), $urandom_range(1) ? "x9" : "");
      8: id = $sformatf("-%s", digit_run($urandom_range(9, 13)));
      default: begin
        case ($urandom_range(3))
          0: id = "2147483647";
          1: id = "2147483648";
          2: id = "-2147483648";
          default: id = "-2147483649";
        endcase
      end
    endcase
    if ($urandom_range(5) == 0) id = {"+00", id};
    for (i = 0; i < id.len(); i++) q.push_back(id[i]);
    q.push_back(CH_COMMA);
    n = $urandom_range(6);
    repeat (n) begin
      b = 8'($urandom_range(255));
      q.push_back(b == CH_NL ? CH_COMMA : b);
    end
    if ($urandom_range(2) == 0) q.push_back(CH_CR);
    foreach (q[k]) send_data(q[k]);
    if ($urandom_range(7) == 0) begin
      send_eof();
    end else begin
      send_data(CH_NL);
    end
  endtask

  task automatic send_noise();
    int n;
    case ($urandom_range(3))
      0: begin
        n = $urandom_range(1, 8);
        repeat (n) send_data(8'($urandom_range(255)));
      end
      1: begin
        send_str($sformatf("%0d abc", $urandom_range(99)));
        send_data(CH_NL);
      end
      2: send_eof();
      default: begin
        send_data(CH_COMMA);
        send_str("tail");
        send_eof();
      end
    endcase
  endtask

  task automatic traffic(input int count);
    int stop_at;
    stop_at = sent + count;
    while (sent < stop_at) begin
      if ($urandom_range(3) == 0) begin
        send_noise();
      end else begin
        send_line();
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (LAT_PAD) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [ROW_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_capacity(v);
  endtask

  task automatic directed();
    send_str("1,ab");
    send_data(CH_NL);
    send_data(CH_SPACE);
    send_data(CH_TAB);
    send_str("+2,x");
    send_data(CH_CR);
    send_data(CH_NL);
    send_str("-2147483649,");
    send_data(CH_NL);
    send_str("99999999999,");
    send_data(CH_CR);
    send_data(CH_NL);
    send_str("-,z");
    send_data(CH_NL);
    send_str("no comma");
    send_data(CH_NL);
    send_data(CH_NL);
    send_str("7a9,a,b");
    send_eof();
    send_eof();
    send_data(CH_VT);
    send_data(CH_FF);
    send_data(CH_CR);
    send_str("5,");
    send_data(8'hFF);
    send_data(8'h00);
    send_eof();
  endtask

  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) tracker.match_row(out_rsp);
      if (recv_hold > 0) begin
        out_ready <= 1'b0;
        recv_hold = recv_hold - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("csv_row_indexer_tb: done, errors");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_capacity(CAP_RESET);
    directed();
    settle();

    write_capacity(tracker.rows_seen + 32'd2000 + $urandom_range(1 << 20));
    send_idle_pct = 21;
    recv_idle_pct = 75;
    traffic(150);
    settle();

    // hold the result side while short rows pile up behind it
    recv_hold = 300;
    send_idle_pct = 0;
    repeat (20) begin
      send_str($sformatf("%0d,z", tracker.rows_seen + 1));
      send_data(CH_NL);
    end
    settle();

    write_capacity(CAP_RESET - $urandom_range(1000));
    send_idle_pct = 75;
    recv_idle_pct = 21;
    traffic(150);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    traffic(150);
    settle();

    // run into the capacity limit, then confirm the block stays silent
    write_capacity(tracker.rows_seen + 3);
    send_idle_pct = 21;
    recv_idle_pct = 21;
    while (!tracker.halted) send_line();
    traffic(20);
    settle();
    write_capacity('0);
    traffic(20);
    settle();

    if (tracker.errors == 0) begin
      $display("csv_row_indexer_tb: done, clean");
    end else begin
      $display("csv_row_indexer_tb: done, errors");
    end
    $finish;
  end

endmodule
